@@ src/allele_site_llr_core_defines.svh @@
// Assertion macros for the allele site LLR core.
`ifndef ALLELE_SITE_LLR_CORE_DEFINES_SVH
`define ALLELE_SITE_LLR_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk while out of reset.
`define ASL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allele_site_llr_core: same-cycle check failed");

// Next-cycle implication, checked on clk while out of reset.
`define ASL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allele_site_llr_core: next-cycle check failed");

`endif

@@ src/asl_pkg.sv @@
// Constants, widths and the constant log function of the allele site LLR core.
package asl_pkg;

  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int GUARD      = 28;

  localparam int CW   = COUNT_BITS;
  localparam int KW   = $clog2(CW);
  localparam int YW   = GUARD + 1;
  localparam int LGW  = KW + GUARD;
  localparam int LNW  = LGW;
  localparam int PW   = CW + LNW;
  localparam int AW   = PW + 2;
  localparam int SH   = GUARD - FRAC_BITS;

  localparam int MAJOR_W  = 16;
  localparam int LLR_W    = 36;
  localparam int STATUS_W = 2;

  localparam logic [GUARD-1:0] LN2_Q28 = GUARD'(186065279);
  localparam logic [LLR_W-1:0] LLR_MAX = {1'b0, {(LLR_W-1){1'b1}}};

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER = 2'd2;

  localparam int LANE_M = 0;
  localparam int LANE_N = 1;
  localparam int LANE_T = 2;
  localparam int LANES  = 3;

  // Natural log of an integer in Q28, same squaring method as the datapath.
  function automatic logic [63:0] lnq_f(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] lg;
    logic [63:0] frac;
    int          k;
    frac = 64'd0;
    k    = 0;
    if (x == 64'd0) return 64'd0;
    for (int i = 0; i < 40; i++) begin
      if ((x >> (i + 1)) != 64'd0) k = i + 1;
    end
    y = x << (GUARD - k);
    for (int i = 0; i < GUARD; i++) begin
      y    = (y * y) >> GUARD;
      frac = frac << 1;
      if (y >= (64'd2 << GUARD)) begin
        y    = y >> 1;
        frac = frac | 64'd1;
      end
    end
    lg = (64'(k) << GUARD) | frac;
    return (lg * 64'(LN2_Q28) + (64'd1 << (GUARD - 1))) >> GUARD;
  endfunction

  localparam logic [LNW-1:0] L199 = LNW'(lnq_f(64'd199));
  localparam logic [LNW-1:0] L200 = LNW'(lnq_f(64'd200));
  localparam logic [LNW-1:0] LDIF = L200 - L199;

endpackage

@@ src/asl_if.sv @@
// Valid/ready channel interfaces for site words and result words.
interface asl_in_if;
  logic        valid;
  logic        ready;
  logic        alleles_match;
  logic [15:0] total_reads;
  logic [15:0] minor_reads;
  modport source (output valid, output alleles_match, output total_reads,
                  output minor_reads, input ready);
  modport sink   (input valid, input alleles_match, input total_reads,
                  input minor_reads, output ready);
endinterface

interface asl_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] major_reads;
  logic signed [35:0] llr;
  logic        [1:0]  status;
  modport source (output valid, output major_reads, output llr, output status,
                  input ready);
  modport sink   (input valid, input major_reads, input llr, input status,
                  output ready);
endinterface

@@ src/allele_site_llr_core.sv @@
// Allele site LLR core: takes one site word per cycle unless the pipeline is
// stalled, and returns one result word per site through a 35-stage pipeline.
// The latency is set by the 28 squaring stages of the log2 units (one unit
// per lane for the major, minor and total counts); each stage of a unit holds
// one 29x29 multiply. Every stage may advance on its own, so bubbles close up
// and a word is accepted whenever the first stage is empty or moving, also
// while a finished result waits.
`include "allele_site_llr_core_defines.svh"

module allele_site_llr_core
  import asl_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  asl_in_if.sink        in_port,
  asl_out_if.source     out_port
);

  localparam int NS   = 35;
  localparam int S_FR = 0;
  localparam int S_NM = 1;
  localparam int S_SQ = 2;
  localparam int S_LN = S_SQ + GUARD;
  localparam int S_PR = S_LN + 1;
  localparam int S_SA = S_PR + 1;
  localparam int S_QQ = S_SA + 1;

  typedef struct packed {
    logic [STATUS_W-1:0]             status;
    logic                            lowc;
    logic                            highc;
    logic [CW-1:0]                   m;
    logic [CW-1:0]                   n;
    logic [CW-1:0]                   t;
    logic [LANES-1:0][KW-1:0]        k;
    logic [LANES-1:0][YW-1:0]        y;
    logic [LANES-1:0][GUARD-1:0]     frac;
    logic [LANES-1:0][LNW-1:0]       ln;
    logic [PW-1:0]                   pm;
    logic [PW-1:0]                   pn;
    logic [PW-1:0]                   pt;
    logic [PW-1:0]                   pdm;
    logic [PW-1:0]                   pdn;
    logic [PW-1:0]                   plow;
    logic [AW-1:0]                   a1;
    logic [AW-1:0]                   a2;
    logic [AW-1:0]                   q;
  } stage_t;

  typedef struct packed {
    logic [MAJOR_W-1:0]     major_reads;
    logic [LLR_W-1:0]       llr;
    logic [STATUS_W-1:0]    status;
  } result_t;

  stage_t            pipe_r   [NS-1];
  stage_t            pipe_nxt [NS-1];
  result_t           res_r;
  result_t           res_nxt;
  logic [NS-1:0]     v_r;
  logic [NS:0]       en;

  // Stage advances when empty or when the stage after it advances.
  always_comb begin
    en[NS] = out_port.ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_port.ready = en[0];

  // Front: status, major/minor split, clamp tests.
  always_comb begin
    logic [CW-1:0]   t;
    logic [CW-1:0]   mn;
    logic [CW-1:0]   m;
    logic [CW+7:0]   m200;
    logic [CW+7:0]   n200;
    t  = in_port.total_reads[CW-1:0];
    mn = in_port.minor_reads[CW-1:0];
    pipe_nxt[S_FR] = '0;
    if (t == '0)     pipe_nxt[S_FR].status = ST_ZERO;
    else if (mn > t) pipe_nxt[S_FR].status = ST_OVER;
    else             pipe_nxt[S_FR].status = ST_OK;
    m = in_port.alleles_match ? (t - mn) : mn;
    pipe_nxt[S_FR].m = m;
    pipe_nxt[S_FR].n = t - m;
    pipe_nxt[S_FR].t = t;
    m200 = {8'b0, m} * (CW+8)'(200);
    n200 = {8'b0, t - m} * (CW+8)'(200);
    pipe_nxt[S_FR].lowc  = m200 <= {8'b0, t};
    pipe_nxt[S_FR].highc = n200 <= {8'b0, t};
  end

  // Normalize each count to Q28 in [1,2) with its msb index.
  always_comb begin
    logic [LANES-1:0][CW-1:0] x;
    logic [KW-1:0]            k;
    logic [GUARD+CW-1:0]      sh;
    pipe_nxt[S_NM] = pipe_r[S_NM-1];
    x[LANE_M] = pipe_r[S_NM-1].m;
    x[LANE_N] = pipe_r[S_NM-1].n;
    x[LANE_T] = pipe_r[S_NM-1].t;
    for (int l = 0; l < LANES; l++) begin
      k = '0;
      for (int b = 1; b < CW; b++) begin
        if (x[l][b]) k = KW'(b);
      end
      sh = {{GUARD{1'b0}}, x[l]} << (6'(GUARD) - 6'(k));
      pipe_nxt[S_NM].k[l]    = k;
      pipe_nxt[S_NM].y[l]    = sh[YW-1:0];
      pipe_nxt[S_NM].frac[l] = '0;
    end
  end

  // One squaring step per stage: emit one fraction bit of log2.
  for (genvar j = 0; j < GUARD; j++) begin : g_sq
    always_comb begin
      logic [2*YW-1:0] p;
      logic [YW:0]     y2;
      pipe_nxt[S_SQ+j] = pipe_r[S_SQ+j-1];
      for (int l = 0; l < LANES; l++) begin
        p  = pipe_r[S_SQ+j-1].y[l] * pipe_r[S_SQ+j-1].y[l];
        y2 = p[GUARD+YW:GUARD];
        if (y2[YW]) begin
          pipe_nxt[S_SQ+j].y[l]    = y2[YW:1];
          pipe_nxt[S_SQ+j].frac[l] = {pipe_r[S_SQ+j-1].frac[l][GUARD-2:0], 1'b1};
        end else begin
          pipe_nxt[S_SQ+j].y[l]    = y2[YW-1:0];
          pipe_nxt[S_SQ+j].frac[l] = {pipe_r[S_SQ+j-1].frac[l][GUARD-2:0], 1'b0};
        end
      end
    end
  end

  // Scale log2 by ln2 and round half up to Q28.
  always_comb begin
    logic [LGW+GUARD-1:0] prod;
    pipe_nxt[S_LN] = pipe_r[S_LN-1];
    for (int l = 0; l < LANES; l++) begin
      prod = {pipe_r[S_LN-1].k[l], pipe_r[S_LN-1].frac[l]} * (LGW+GUARD)'(LN2_Q28)
             + ((LGW+GUARD)'(1) << (GUARD - 1));
      pipe_nxt[S_LN].ln[l] = prod[LGW+GUARD-1:GUARD];
      // x = 0 gives y = 0 and k = 0; log is zero then
      if (pipe_r[S_LN-1].y[l] == '0) pipe_nxt[S_LN].ln[l] = '0;
    end
  end

  // Count times log products.
  always_comb begin
    stage_t s;
    s = pipe_r[S_PR-1];
    pipe_nxt[S_PR]      = s;
    pipe_nxt[S_PR].pm   = PW'(s.m) * PW'(s.ln[LANE_M]);
    pipe_nxt[S_PR].pn   = PW'(s.n) * PW'(s.ln[LANE_N]);
    pipe_nxt[S_PR].pt   = PW'(s.t) * PW'(s.ln[LANE_T]);
    pipe_nxt[S_PR].pdm  = PW'(s.m) * PW'(LDIF);
    pipe_nxt[S_PR].pdn  = PW'(s.n) * PW'(L200);
    pipe_nxt[S_PR].plow = PW'(s.t - (s.m << 1)) * PW'(L199);
  end

  // Partial sums.
  always_comb begin
    pipe_nxt[S_SA]    = pipe_r[S_SA-1];
    pipe_nxt[S_SA].a1 = AW'(pipe_r[S_SA-1].pm) + AW'(pipe_r[S_SA-1].pn);
    pipe_nxt[S_SA].a2 = AW'(pipe_r[S_SA-1].pdm) + AW'(pipe_r[S_SA-1].pdn);
  end

  // Select the clamp case; drop a negative residue to zero.
  always_comb begin
    logic [AW-1:0] a;
    logic [AW-1:0] b;
    a = pipe_r[S_QQ-1].a1 + pipe_r[S_QQ-1].a2;
    b = AW'(pipe_r[S_QQ-1].pt);
    pipe_nxt[S_QQ] = pipe_r[S_QQ-1];
    if (pipe_r[S_QQ-1].lowc)       pipe_nxt[S_QQ].q = AW'(pipe_r[S_QQ-1].plow);
    else if (pipe_r[S_QQ-1].highc) pipe_nxt[S_QQ].q = '0;
    else if (a > b)                pipe_nxt[S_QQ].q = a - b;
    else                           pipe_nxt[S_QQ].q = '0;
  end

  // Round to FRAC_BITS, saturate, force error words to zero.
  always_comb begin
    logic [AW:0] v;
    v = ({1'b0, pipe_r[NS-2].q} + ((AW+1)'(1) << (SH - 1))) >> SH;
    res_nxt.status = pipe_r[NS-2].status;
    if (pipe_r[NS-2].status != ST_OK) begin
      res_nxt.major_reads = '0;
      res_nxt.llr         = '0;
    end else begin
      res_nxt.major_reads = MAJOR_W'(pipe_r[NS-2].m);
      if (v > (AW+1)'(LLR_MAX)) res_nxt.llr = LLR_MAX;
      else                      res_nxt.llr = LLR_W'(v);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS - 1; i++) begin
      if (en[i]) pipe_r[i] <= pipe_nxt[i];
    end
    if (en[NS-1]) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_port.valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign out_port.valid       = v_r[NS-1];
  assign out_port.major_reads = res_r.major_reads;
  assign out_port.llr         = res_r.llr;
  assign out_port.status      = res_r.status;

  `ASL_ASSERT_NXT(a_enter, in_port.valid && en[0], v_r[0])
  `ASL_ASSERT_IMP(a_err_zero, out_port.valid && (out_port.status != ST_OK),
                  (out_port.llr == '0) && (out_port.major_reads == '0))
  `ASL_ASSERT_IMP(a_llr_nonneg, out_port.valid, !out_port.llr[LLR_W-1])

endmodule

@@ tb/sv/asl_llr_checker.sv @@
// Checker for the allele site LLR core: predicts each site result and compares.
`timescale 1ns / 1ps

module asl_llr_checker
  import asl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  asl_in_if    in_mon,
  asl_out_if   out_mon,
  output int   err_cnt,
  output int   pending_cnt,
  output int   site_cnt,
  output int   result_cnt
);

  typedef struct packed {
    logic [15:0]       major;
    logic [35:0]       llr;
    logic [1:0]        status;
  } site_result_t;

  site_result_t result_q[$];

  // Natural log of an integer in Q28 by repeated squaring of the mantissa.
  function automatic logic [63:0] ln_fix(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] lg2;
    logic [63:0] bits;
    int          msb;
    bits = 64'd0;
    msb  = 0;
    if (x == 64'd0) return 64'd0;
    for (int i = 0; i < 40; i++) begin
      if ((x >> (i + 1)) != 64'd0) msb = i + 1;
    end
    y = (msb <= 28) ? (x << (28 - msb)) : (x >> (msb - 28));
    for (int i = 0; i < 28; i++) begin
      y    = (y * y) >> 28;
      bits = bits << 1;
      if (y >= (64'd2 << 28)) begin
        y    = y >> 1;
        bits = bits | 64'd1;
      end
    end
    lg2 = (64'(msb) << 28) | bits;
    return (lg2 * 64'd186065279 + (64'd1 << 27)) >> 28;
  endfunction

  function automatic site_result_t site_llr(input logic match, input logic [15:0] tot,
                                            input logic [15:0] minor);
    site_result_t r;
    logic [63:0]  t, m, n, q, v, a, b, l199, l200;
    r = '0;
    t = 64'(tot);
    if (tot == 16'd0) begin
      r.status = ST_ZERO;
      return r;
    end
    if (minor > tot) begin
      r.status = ST_OVER;
      return r;
    end
    m = match ? (t - 64'(minor)) : 64'(minor);
    n = t - m;
    l199 = ln_fix(64'd199);
    l200 = ln_fix(64'd200);
    if (200 * m <= t) begin
      q = (t - 2 * m) * l199;
    end else if (200 * n <= t) begin
      q = 64'd0;
    end else begin
      a = m * ln_fix(m) + n * ln_fix(n) + m * (l200 - l199) + n * l200;
      b = t * ln_fix(t);
      // clamp rounding residue at zero
      q = (a > b) ? (a - b) : 64'd0;
    end
    v = (q + (64'd1 << (GUARD - FRAC_BITS - 1))) >> (GUARD - FRAC_BITS);
    if (v > 64'(LLR_MAX)) v = 64'(LLR_MAX);
    r.major  = m[15:0];
    r.llr    = v[35:0];
    r.status = ST_OK;
    return r;
  endfunction

  assign pending_cnt = result_q.size();

  initial begin
    err_cnt    = 0;
    site_cnt   = 0;
    result_cnt = 0;
  end

  always @(posedge clk) begin
    site_result_t exp_r;
    if (rst_n) begin
      // retire result word before queuing the new site word
      if (out_mon.valid && out_mon.ready) begin
        result_cnt++;
        if (result_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("%0t: result word with none expected", $realtime);
        end else begin
          exp_r = result_q.pop_front();
          if (out_mon.major_reads !== exp_r.major || out_mon.llr !== exp_r.llr ||
              out_mon.status !== exp_r.status) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch exp major=%0d llr=%0d st=%0d got major=%0d llr=%0d st=%0d",
                       $realtime, exp_r.major, exp_r.llr, exp_r.status,
                       out_mon.major_reads, out_mon.llr, out_mon.status);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        site_cnt++;
        result_q.push_back(site_llr(in_mon.alleles_match, in_mon.total_reads,
                                    in_mon.minor_reads));
      end
    end
  end

endmodule

@@ tb/sv/tb_allele_site_llr_core.sv @@
// Testbench top for the allele site LLR core: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_allele_site_llr_core;
  import asl_pkg::*;

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   err_cnt, pending_cnt, site_cnt, result_cnt;

  asl_in_if  in_ch();
  asl_out_if out_ch();

  allele_site_llr_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_ch),
    .out_port (out_ch)
  );

  asl_llr_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .err_cnt     (err_cnt),
    .pending_cnt (pending_cnt),
    .site_cnt    (site_cnt),
    .result_cnt  (result_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_site(input logic match, input logic [15:0] tot,
                           input logic [15:0] minor);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.alleles_match <= match;
    in_ch.total_reads   <= tot;
    in_ch.minor_reads   <= minor;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_site();
    logic [15:0] tot;
    logic [15:0] minor;
    int          pick;
    pick = $urandom_range(99);
    tot  = (pick < 45) ? 16'($urandom_range(1, 1000)) : 16'($urandom_range(1, 65535));
    if (pick < 4) begin
      tot   = 16'd0;
      minor = 16'($urandom);
    end else if (pick < 12 && tot != 16'hFFFF) begin
      minor = 16'($urandom_range(tot + 1, 65535));
    end else if (pick < 30) begin
      // land near the clamp edges
      minor = 16'($urandom_range(0, tot / 150 + 1));
      if (minor > tot) minor = tot;
      if ($urandom_range(1)) minor = tot - minor;
    end else begin
      minor = 16'($urandom_range(0, tot));
    end
    send_site(1'($urandom), tot, minor);
  endtask

  task automatic drain();
    while (pending_cnt != 0) @(negedge clk);
  endtask

  initial begin
    rst_n               = 1'b0;
    idle_pct            = 0;
    stall_pct           = 0;
    in_ch.valid         = 1'b0;
    in_ch.alleles_match = 1'b0;
    in_ch.total_reads   = 16'd0;
    in_ch.minor_reads   = 16'd0;
    out_ch.ready        = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero total, minor above total, extremes, clamp edges, middle range
    send_site(1'b0, 16'd0, 16'd0);
    send_site(1'b1, 16'd0, 16'd7);
    send_site(1'b1, 16'd0, 16'hFFFF);
    send_site(1'b0, 16'd10, 16'd11);
    send_site(1'b1, 16'hFFFE, 16'hFFFF);
    send_site(1'b0, 16'hFFFF, 16'd0);
    send_site(1'b1, 16'hFFFF, 16'd0);
    send_site(1'b0, 16'hFFFF, 16'hFFFF);
    send_site(1'b1, 16'hFFFF, 16'hFFFF);
    send_site(1'b0, 16'd1, 16'd0);
    send_site(1'b1, 16'd1, 16'd0);
    send_site(1'b0, 16'd1, 16'd1);
    send_site(1'b0, 16'd200, 16'd1);
    send_site(1'b0, 16'd201, 16'd1);
    send_site(1'b1, 16'd200, 16'd1);
    send_site(1'b1, 16'd201, 16'd1);
    send_site(1'b0, 16'd100, 16'd50);
    send_site(1'b1, 16'd1000, 16'd300);
    send_site(1'b0, 16'hAAAA, 16'h5555);
    send_site(1'b1, 16'h5555, 16'h2AAA);
    send_site(1'b0, 16'hFFFF, 16'h8000);
    send_site(1'b0, 16'hFFFF, 16'd327);
    send_site(1'b0, 16'hFFFF, 16'd328);

    // hold the sender until the pipeline is empty
    in_ch.valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      repeat (370) send_random_site();
    end
    in_ch.valid <= 1'b0;
    drain();
    repeat (60) @(negedge clk);

    $display("Sent %0d site words, checked %0d result words across four idle/stall mixes,",
             site_cnt, result_cnt);
    $display("covering zero totals, minor overflow, both clamps and the middle range.");
    if (err_cnt == 0 && pending_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/asl_pkg.sv
src/asl_if.sv
src/allele_site_llr_core.sv
tb/sv/asl_llr_checker.sv
tb/sv/tb_allele_site_llr_core.sv
